[sv/udepq_pkg.sv]
// ----------------------------------------------------------------------------
// Unsorted double-ended priority queue package
// Shared constants, request and response types and the cell interface types.
// ----------------------------------------------------------------------------
package udepq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_MIN  = 2'd1;
   localparam logic [1:0] REQ_MAX  = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] push_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] removed_value;
      logic [1:0]         status;
      logic [CNT_W-1:0]   occupancy;
   } rsp_payload_type;

   typedef struct packed {
      logic write_en;
      logic shift_en;
      logic live;
      logic want_max;
   } cell_ctrl_type;

   typedef struct packed {
      logic               vld;
      logic signed [31:0] value;
      logic [IDX_W-1:0]   idx;
   } cand_type;

   // True when the cell's own value beats the candidate handed in; a tie keeps
   // the earlier candidate.
   function automatic logic beats(input logic signed [31:0] own,
                                  input logic signed [31:0] prev,
                                  input logic want_max);
      logic result;
      if (want_max) begin
         result = prev < own;
      end else begin
         result = own < prev;
      end
      return result;
   endfunction

endpackage

[sv/udepq_cell.sv]
// ----------------------------------------------------------------------------
// Queue cell
// Holds one stored value and one stage of the search candidate that travels
// along the row of cells.
// ----------------------------------------------------------------------------
module udepq_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  udepq_pkg::cell_ctrl_type ctrl,
   input  logic [udepq_pkg::IDX_W-1:0] cell_index,
   input  logic signed [31:0]       push_value,
   input  logic signed [31:0]       next_value,
   input  udepq_pkg::cand_type      cand_prev,
   output logic signed [31:0]       value,
   output udepq_pkg::cand_type      cand
);

   logic signed [31:0]  value_ff;
   logic signed [31:0]  value_in;
   udepq_pkg::cand_type cand_ff;
   udepq_pkg::cand_type cand_in;

   always_comb begin
      value_in = value_ff;
      if (ctrl.write_en) begin
         value_in = push_value;
      end else if (ctrl.shift_en) begin
         value_in = next_value;
      end
   end

   always_comb begin
      cand_in = cand_prev;
      if (cand_prev.vld && ctrl.live &&
          udepq_pkg::beats(value_ff, cand_prev.value, ctrl.want_max)) begin
         cand_in.value = value_ff;
         cand_in.idx   = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      cand_ff.value <= cand_in.value;
      cand_ff.idx   <= cand_in.idx;
      if (reset) begin
         cand_ff.vld <= 1'b0;
      end else begin
         cand_ff.vld <= cand_in.vld;
      end
   end

   assign value = value_ff;
   assign cand  = cand_ff;

endmodule

[sv/unsorted_double_ended_priority_queue_unit.sv]
// ----------------------------------------------------------------------------
// Unsorted double-ended priority queue unit
// Stores up to CAPACITY signed values in arrival order and removes the
// smallest or largest on request.
// ----------------------------------------------------------------------------
// A push, an overflowing push, an underflowing removal or an unused request
// code needs no search: busy stays low and the registered response strobe
// follows in the cycle after start. A removal from a non-empty queue holds
// busy high while the search candidate walks one cell per cycle along the
// whole row of cells, after which the later entries close the gap together.
// Every request gives exactly one response, shown for one
// cycle on rsp_strobe; the receiver must take it then, as it cannot stall.
// ----------------------------------------------------------------------------
module unsorted_double_ended_priority_queue_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  udepq_pkg::req_payload_type req_data,
   output logic                       rsp_strobe,
   output udepq_pkg::rsp_payload_type rsp_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                         state_ff;
   logic                         state_in;
   logic [udepq_pkg::CNT_W-1:0]  cnt_ff;
   logic [udepq_pkg::CNT_W-1:0]  cnt_in;
   logic                         start_ff;
   logic                         start_in;
   logic                         mode_ff;
   logic                         mode_in;
   logic                         rsp_strobe_ff;
   logic                         rsp_strobe_in;
   udepq_pkg::rsp_payload_type   rsp_data_ff;
   udepq_pkg::rsp_payload_type   rsp_data_in;

   logic                         accept;
   logic                         push_ok;
   logic                         finish;
   logic                         empty;
   logic                         full;
   udepq_pkg::cand_type          cand_last;
   udepq_pkg::cand_type          cand_head;

   logic signed [31:0]           values [udepq_pkg::CAPACITY];
   udepq_pkg::cand_type          cands  [udepq_pkg::CAPACITY];
   udepq_pkg::cell_ctrl_type     ctrls  [udepq_pkg::CAPACITY];

   assign busy      = (state_ff == ST_SCAN);
   assign accept    = start && !busy;
   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff == udepq_pkg::CNT_W'(udepq_pkg::CAPACITY));
   assign push_ok   = accept && (req_data.req_type == udepq_pkg::REQ_PUSH) && !full;
   assign cand_last = cands[udepq_pkg::CAPACITY-1];
   assign finish    = cand_last.vld;

   always_comb begin
      cand_head.vld   = start_ff;
      cand_head.value = values[0];
      cand_head.idx   = '0;
   end

   for (genvar i = 0; i < udepq_pkg::CAPACITY; i++) begin : g_cell
      logic signed [31:0] next_value;

      if (i + 1 < udepq_pkg::CAPACITY) begin : g_mid
         assign next_value = values[i+1];
      end else begin : g_end
         assign next_value = values[i];
      end

      always_comb begin
         ctrls[i].write_en = push_ok && (cnt_ff[udepq_pkg::IDX_W-1:0] ==
                                         udepq_pkg::IDX_W'(i));
         ctrls[i].shift_en = finish && (udepq_pkg::IDX_W'(i) >= cand_last.idx);
         ctrls[i].live     = cnt_ff > udepq_pkg::CNT_W'(i);
         ctrls[i].want_max = mode_ff;
      end

      if (i == 0) begin : g_head
         udepq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrls[i]),
            .cell_index (udepq_pkg::IDX_W'(i)),
            .push_value (req_data.push_value),
            .next_value (next_value),
            .cand_prev  (cand_head),
            .value      (values[i]),
            .cand       (cands[i])
         );
      end else begin : g_tail
         udepq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrls[i]),
            .cell_index (udepq_pkg::IDX_W'(i)),
            .push_value (req_data.push_value),
            .next_value (next_value),
            .cand_prev  (cands[i-1]),
            .value      (values[i]),
            .cand       (cands[i])
         );
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      start_in      = 1'b0;
      mode_in       = mode_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in               = 1'b1;
               rsp_data_in.removed_value   = '0;
               rsp_data_in.status          = udepq_pkg::STATUS_OK;
               rsp_data_in.occupancy       = cnt_ff;
               case (req_data.req_type) inside
                  udepq_pkg::REQ_PUSH: begin
                     if (full) begin
                        rsp_data_in.status = udepq_pkg::STATUS_OVERFLOW;
                     end else begin
                        cnt_in                = cnt_ff + udepq_pkg::CNT_W'(1);
                        rsp_data_in.occupancy = cnt_ff + udepq_pkg::CNT_W'(1);
                     end
                  end
                  udepq_pkg::REQ_MIN, udepq_pkg::REQ_MAX: begin
                     if (empty) begin
                        rsp_data_in.status        = udepq_pkg::STATUS_UNDERFLOW;
                        rsp_data_in.removed_value = '1;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        state_in      = ST_SCAN;
                        start_in      = 1'b1;
                        mode_in       = (req_data.req_type == udepq_pkg::REQ_MAX);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in                  = ST_IDLE;
               cnt_in                    = cnt_ff - udepq_pkg::CNT_W'(1);
               rsp_strobe_in             = 1'b1;
               rsp_data_in.removed_value = cand_last.value;
               rsp_data_in.status        = udepq_pkg::STATUS_OK;
               rsp_data_in.occupancy     = cnt_ff - udepq_pkg::CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         start_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         start_ff      <= start_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // The fill count never exceeds the capacity.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= udepq_pkg::CNT_W'(udepq_pkg::CAPACITY))
      else $error("fill count above capacity");

   // A response never appears while a removal is still searching.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while busy");

   // Every accepted request either answers at once or starts a search.
   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("accepted request lost");

   // The search candidate only reaches the end of the row during a search.
   a_finish_scan: assert property (@(posedge clock) disable iff (reset)
      finish |-> (state_ff == ST_SCAN))
      else $error("search result outside a search");

   // A search always ends on a live entry.
   a_finish_live: assert property (@(posedge clock) disable iff (reset)
      finish |-> (udepq_pkg::CNT_W'(cand_last.idx) < cnt_ff))
      else $error("search picked an empty cell");

endmodule
